// File: hdl/cle_pkg.sv
// shared constants, codes and controller/datapath struct types for the circular list engine
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int ENTR_W   = 6;

	typedef enum logic [1:0] {
		FUNC_INS_FRONT = 2'd0,
		FUNC_INS_END   = 2'd1,
		FUNC_DELETE    = 2'd2,
		FUNC_DUMP      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_A,
		S_INS_B,
		S_DEL_START,
		S_DEL_WALK,
		S_DUMP_START,
		S_DUMP_WALK,
		S_RESP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic ins_a;
		logic ins_b;
		logic del_start;
		logic del_walk;
		logic dump_start;
		logic dump_walk;
		logic resp;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		func_t req_func;
		logic  empty;
		logic  full;
		logic  match;
		logic  walk_end;
		logic  out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: hdl/cle_req_if.sv
// request channel: valid/ready handshake with function code and value
`timescale 1ns / 1ps
`default_nettype none
interface cle_req_if;
	logic                                  valid;
	logic                                  ready;
	cle_pkg::func_t                        func;
	logic signed [cle_pkg::VAL_W-1:0]      value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface
`default_nettype wire

// File: hdl/cle_rsp_if.sv
// result channel: valid/ready handshake with listed value, status, count and last mark
`timescale 1ns / 1ps
`default_nettype none
interface cle_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cle_pkg::VAL_W-1:0]      item_value;
	cle_pkg::status_t                      status;
	logic [cle_pkg::ENTR_W-1:0]            entries_now;
	logic                                  last;

	modport source (output valid, output item_value, output status, output entries_now,
		output last, input ready);
	modport sink   (input valid, input item_value, input status, input entries_now,
		input last, output ready);
endinterface
`default_nettype wire

// File: hdl/cle_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/cle_datapath.sv
// list datapath: entry memories, free map, head/tail pointers, walk registers, result register
`timescale 1ns / 1ps
`default_nettype none
module cle_datapath (
	input  wire            clk,
	input  wire            arst_n,
	input  wire cle_pkg::cmd_t cmd,
	output cle_pkg::stat_t stat,
	cle_req_if.sink        req,
	cle_rsp_if.source      rsp
);

	localparam int IDX_W = cle_pkg::IDX_W;
	localparam int CNT_W = cle_pkg::CNT_W;
	localparam int VAL_W = cle_pkg::VAL_W;

	logic [IDX_W-1:0]          front_q, back_q, cur_q, prev_q, slot_q;
	logic [CNT_W-1:0]          count_q, i_q;
	logic [cle_pkg::CAPACITY-1:0] free_q;
	logic [VAL_W-1:0]          key_q;
	cle_pkg::status_t          st_q;
	cle_pkg::func_t            func_q;

	logic                      out_valid_q;
	logic [VAL_W-1:0]          out_value_q;
	cle_pkg::status_t          out_status_q;
	logic [CNT_W-1:0]          out_count_q;
	logic                      out_last_q;

	logic [VAL_W-1:0]          val_rd;
	logic [IDX_W-1:0]          link_rd;
	logic [IDX_W-1:0]          free_slot;
	logic                      full, empty, one_left, match, walk_end, out_free;
	logic                      v_we, l_we, re;
	logic [IDX_W-1:0]          l_waddr, l_wdata, raddr;
	logic                      load_resp, load_dump, del_hit;

	function automatic logic req_at_front();
		return (func_q == cle_pkg::FUNC_INS_FRONT);
	endfunction

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = cle_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = IDX_W'(i);
			end
		end
	end

	assign full     = (count_q == CNT_W'(cle_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign one_left = (count_q == CNT_W'(1));
	assign match    = (val_rd == key_q);
	assign walk_end = ((i_q + CNT_W'(1)) == count_q);
	assign out_free = !out_valid_q || rsp.ready;

	assign load_resp = cmd.resp && out_free;
	assign load_dump = cmd.dump_walk && out_free;
	assign del_hit   = cmd.del_walk && match;

	assign stat.req_func = req.func;
	assign stat.empty    = empty;
	assign stat.full     = full;
	assign stat.match    = match;
	assign stat.walk_end = walk_end;
	assign stat.out_free = out_free;

	// memory ports
	assign v_we = cmd.ins_a && !full;
	assign re   = cmd.del_start || cmd.dump_start || cmd.del_walk || load_dump;
	assign raddr = (cmd.del_start || cmd.dump_start) ? front_q : link_rd;

	always_comb begin
		l_we    = 1'b0;
		l_waddr = free_slot;
		l_wdata = empty ? free_slot : front_q;
		if (cmd.ins_a && !full) begin
			l_we = 1'b1;
		end else if (cmd.ins_b) begin
			l_we    = 1'b1;
			l_waddr = back_q;
			l_wdata = slot_q;
		end else if (del_hit && !one_left) begin
			l_we    = 1'b1;
			l_waddr = prev_q;
			l_wdata = link_rd;
		end
	end

	cle_ram #(.WIDTH(VAL_W), .DEPTH(cle_pkg::CAPACITY)) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (free_slot),
		.wdata (key_q),
		.re    (re),
		.raddr (raddr),
		.rdata (val_rd)
	);

	cle_ram #(.WIDTH(IDX_W), .DEPTH(cle_pkg::CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (link_rd)
	);

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			free_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_a && !full) begin
				free_q[free_slot] <= 1'b0;
				if (empty) begin
					front_q <= free_slot;
					back_q  <= free_slot;
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.ins_b) begin
				if (req_at_front()) begin
					front_q <= slot_q;
				end else begin
					back_q <= slot_q;
				end
				count_q <= count_q + CNT_W'(1);
			end
			if (del_hit) begin
				free_q[cur_q] <= 1'b1;
				count_q       <= count_q - CNT_W'(1);
				if (one_left) begin
					front_q <= '0;
					back_q  <= '0;
				end else begin
					if (cur_q == front_q) begin
						front_q <= link_rd;
					end
					if (cur_q == back_q) begin
						back_q <= prev_q;
					end
				end
			end
			if (load_resp || load_dump) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and walk registers, result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req.func;
			key_q  <= req.value;
			st_q   <= (req.func == cle_pkg::FUNC_DUMP) ? cle_pkg::ST_EMPTY
				: cle_pkg::ST_NOT_FOUND;
		end
		if (cmd.ins_a) begin
			slot_q <= free_slot;
			st_q   <= full ? cle_pkg::ST_FULL : cle_pkg::ST_OK;
		end
		if (cmd.del_start || cmd.dump_start) begin
			cur_q  <= front_q;
			prev_q <= back_q;
			i_q    <= '0;
		end
		if (cmd.del_walk) begin
			if (match) begin
				st_q <= cle_pkg::ST_OK;
			end else begin
				cur_q  <= link_rd;
				prev_q <= cur_q;
				i_q    <= i_q + CNT_W'(1);
			end
		end
		if (load_dump) begin
			i_q          <= i_q + CNT_W'(1);
			out_value_q  <= val_rd;
			out_status_q <= cle_pkg::ST_OK;
			out_count_q  <= count_q;
			out_last_q   <= walk_end;
		end else if (load_resp) begin
			out_value_q  <= '0;
			out_status_q <= st_q;
			out_count_q  <= count_q;
			out_last_q   <= 1'b1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.item_value  = out_value_q;
	assign rsp.status      = out_status_q;
	assign rsp.entries_now = cle_pkg::ENTR_W'(out_count_q);
	assign rsp.last        = out_last_q;

endmodule
`default_nettype wire

// File: hdl/cle_ctrl.sv
// request sequencer: steps each request through insert, delete walk, dump walk and result
`timescale 1ns / 1ps
`default_nettype none
module cle_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  wire cle_pkg::stat_t stat,
	output cle_pkg::cmd_t  cmd
);

	cle_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cle_pkg::S_IDLE: begin
				if (req_valid) begin
					case (stat.req_func) inside
						cle_pkg::FUNC_INS_FRONT, cle_pkg::FUNC_INS_END: begin
							state_d = cle_pkg::S_INS_A;
						end
						cle_pkg::FUNC_DELETE: begin
							state_d = stat.empty ? cle_pkg::S_RESP : cle_pkg::S_DEL_START;
						end
						default: begin
							state_d = stat.empty ? cle_pkg::S_RESP : cle_pkg::S_DUMP_START;
						end
					endcase
				end
			end
			cle_pkg::S_INS_A: begin
				state_d = (stat.full || stat.empty) ? cle_pkg::S_RESP : cle_pkg::S_INS_B;
			end
			cle_pkg::S_INS_B: begin
				state_d = cle_pkg::S_RESP;
			end
			cle_pkg::S_DEL_START: begin
				state_d = cle_pkg::S_DEL_WALK;
			end
			cle_pkg::S_DEL_WALK: begin
				if (stat.match || stat.walk_end) begin
					state_d = cle_pkg::S_RESP;
				end
			end
			cle_pkg::S_DUMP_START: begin
				state_d = cle_pkg::S_DUMP_WALK;
			end
			cle_pkg::S_DUMP_WALK: begin
				if (stat.out_free && stat.walk_end) begin
					state_d = cle_pkg::S_IDLE;
				end
			end
			cle_pkg::S_RESP: begin
				if (stat.out_free) begin
					state_d = cle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cle_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			cle_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			cle_pkg::S_INS_A:      cmd.ins_a      = 1'b1;
			cle_pkg::S_INS_B:      cmd.ins_b      = 1'b1;
			cle_pkg::S_DEL_START:  cmd.del_start  = 1'b1;
			cle_pkg::S_DEL_WALK:   cmd.del_walk   = 1'b1;
			cle_pkg::S_DUMP_START: cmd.dump_start = 1'b1;
			cle_pkg::S_DUMP_WALK:  cmd.dump_walk  = 1'b1;
			cle_pkg::S_RESP:       cmd.resp       = 1'b1;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/circular_list_engine.sv
// top level of the circular list engine: sequencer, datapath and checks
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid / ready | func, value
//  rsp     | out | valid / ready | item_value, status, entries_now, last
//
// insert runs S_INS_A and S_INS_B when the list holds entries, S_INS_A alone when
// empty or full; delete runs S_DEL_START and S_DEL_WALK to a hit or the last entry,
// and goes straight to the result when empty; dump runs S_DUMP_START and S_DUMP_WALK
// (only the result when empty), one linked-entry read per cycle while output is free
// reset clears pointers, count and free map at once; entry memories are not cleared
// a waiting result is held in the output register; the dump walk pauses while it is held
// a new request is taken once the previous one has handed its last result to the
// output register, even if that result is not yet taken
`timescale 1ns / 1ps
`default_nettype none
module circular_list_engine (
	input  wire       clk,
	input  wire       arst_n,
	cle_req_if.sink   req,
	cle_rsp_if.source rsp
);

	cle_pkg::cmd_t  cmd;
	cle_pkg::stat_t stat;

	// sequencer: one request at a time
	cle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage, pointers and the result register
	cle_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

	// a transfer in starts work, so the next cycle cannot take another
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while previous one still running");

	// a pending dump result that is not the last one means the dump is still running
	a_dump_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> !req.ready)
		else $error("request port open during a dump");

	// error statuses are single results
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != cle_pkg::ST_OK) |-> rsp.last)
		else $error("error status on a non-final result");

	// count never goes past the pool size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (7'(rsp.entries_now) <= 7'(cle_pkg::CAPACITY)))
		else $error("entry count beyond capacity");

endmodule
`default_nettype wire
